// ===== hdl/selective_repeat_receiver_core_defines.svh =====
// Assertion macros used by the receiver back end
`ifndef SELECTIVE_REPEAT_RECEIVER_CORE_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SRR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/srr_pkg.sv =====
// Types, constants and codes of the selective-repeat receiver
package srr_pkg;

  localparam int SEQ_DEPTH   = 1024;
  localparam int WINDOW_MAX  = 63;
  localparam int MAX_DELIVER = 63;
  localparam int ACK_SUM     = 745;

  localparam int SEQ_W      = 10;
  localparam int WIN_W      = 6;
  localparam int CKS_W      = 12;
  localparam int PAYLOAD_W  = 160;
  localparam int BASE_W     = $clog2(SEQ_DEPTH + 1);
  localparam int ADDR_W     = $clog2(SEQ_DEPTH);
  localparam int OFF_W      = $clog2(WINDOW_MAX + 1);
  localparam int FLAG_N     = 2 ** OFF_W;
  localparam int CNT_W      = $clog2(MAX_DELIVER + 1);
  localparam int SUM_W      = 14;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // register index as taken from paddr[2]
  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd8;
  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(1);

  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq_num;
    logic [SEQ_W-1:0]  ack_num;
    logic signed [31:0] rx_checksum;
    logic [63:0]       payload_hi;
    logic [63:0]       payload_mid;
    logic [31:0]       payload_lo;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [SEQ_W-1:0]  out_seq;
    logic [CKS_W-1:0]  ack_checksum;
    logic [63:0]       out_payload_hi;
    logic [63:0]       out_payload_mid;
    logic [31:0]       out_payload_lo;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0]     seq;
    logic [PAYLOAD_W-1:0] payload;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_DELIVER
  } back_state_t;

endpackage

// ===== hdl/srr_ram.sv =====
// Generic simple dual-port RAM with registered read
module srr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/srr_front.sv =====
// Front end: accept packets, check the checksum, push good ones to the queue
module srr_front
  import srr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_stall,
  output logic     q_push,
  output q_item_t  q_wdata,
  input  q_stat_t  q_stat
);

  function automatic logic signed [SUM_W-1:0] byte_sum(input logic [63:0] w);
    logic signed [SUM_W-1:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + SUM_W'($signed(w[8*i +: 8]));
    end
    return s;
  endfunction

  logic                    fr_valid_r, fr_valid_nxt;
  logic [SEQ_W-1:0]        fr_seq_r;
  logic [SEQ_W-1:0]        fr_ack_r;
  logic signed [31:0]      fr_rx_r;
  logic [PAYLOAD_W-1:0]    fr_payload_r;
  logic signed [SUM_W-1:0] fr_sum_hi_r, fr_sum_mid_r, fr_sum_lo_r;

  logic                    accept;
  logic signed [SUM_W-1:0] total;
  logic signed [31:0]      total_ext;
  logic                    good;

  // checksum total over the registered partial sums
  assign total = SUM_W'({1'b0, fr_seq_r}) + SUM_W'({1'b0, fr_ack_r})
               + fr_sum_hi_r + fr_sum_mid_r + fr_sum_lo_r;
  assign total_ext = {{(32 - SUM_W){total[SUM_W-1]}}, total};
  assign good = (total_ext == fr_rx_r);

  assign q_push   = fr_valid_r && good && !q_stat.full;
  assign in_stall = fr_valid_r && good && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign q_wdata  = '{seq: fr_seq_r, payload: fr_payload_r};

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (accept) begin
      fr_valid_nxt = 1'b1;
    end else if (fr_valid_r && !in_stall) begin
      // drop a bad item, or move a good one on
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_seq_r     <= in_data.seq_num;
      fr_ack_r     <= in_data.ack_num;
      fr_rx_r      <= in_data.rx_checksum;
      fr_payload_r <= {in_data.payload_hi, in_data.payload_mid, in_data.payload_lo};
      fr_sum_hi_r  <= byte_sum(in_data.payload_hi);
      fr_sum_mid_r <= byte_sum(in_data.payload_mid);
      fr_sum_lo_r  <= byte_sum({32'd0, in_data.payload_lo});
    end
  end

endmodule

// ===== hdl/srr_queue.sv =====
// Short queue between the front end and the back end
module srr_queue
  import srr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t wdata,
  input  logic    pop,
  output q_item_t rdata,
  output q_stat_t q_stat
);

  q_item_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign rdata        = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hdl/srr_back.sv =====
// Back end: classify against the window, store, ack and drain in order
module srr_back
  import srr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  q_stat_t          q_stat,
  input  q_item_t          q_data,
  output logic             q_pop,
  input  logic [WIN_W-1:0] window_size,
  output logic             out_valid,
  output out_item_t        out_data,
  input  logic             out_stall
);

  `include "selective_repeat_receiver_core_defines.svh"

  back_state_t          state_r, state_nxt;
  logic [BASE_W-1:0]    base_r, base_nxt;
  // received flags from base upwards; everything in [1, base) is received
  logic [FLAG_N-1:0]    flags_r, flags_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_r, out_nxt;

  logic [BASE_W-1:0]    seq_ext;
  logic                 above_base;
  logic [BASE_W-1:0]    off_full;
  logic [OFF_W-1:0]     off;
  logic                 dup;
  logic                 in_win;
  logic [BASE_W-1:0]    win;
  logic [CKS_W-1:0]     ack_cks;
  logic                 out_free;
  logic                 stop;
  logic                 ram_we, ram_re;
  logic [PAYLOAD_W-1:0] ram_rdata;

  srr_ram #(
    .WIDTH (PAYLOAD_W),
    .DEPTH (SEQ_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(q_data.seq)),
    .wdata (q_data.payload),
    .re    (ram_re),
    .raddr (base_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign seq_ext    = BASE_W'(q_data.seq);
  assign above_base = (seq_ext >= base_r);
  assign off_full   = seq_ext - base_r;
  assign off        = off_full[OFF_W-1:0];
  assign win        = (window_size > WIN_W'(WINDOW_MAX)) ? BASE_W'(WINDOW_MAX)
                                                         : BASE_W'(window_size);
  assign dup = (!above_base && q_data.seq != '0)
            || (above_base && off_full < BASE_W'(WINDOW_MAX) && flags_r[off]);
  assign in_win = above_base && (off_full < win) && (seq_ext < BASE_W'(SEQ_DEPTH));
  assign ack_cks  = CKS_W'({q_data.seq, 1'b0}) + CKS_W'(ACK_SUM);
  assign out_free = !out_valid_r || !out_stall;
  assign stop = !flags_r[1] || (base_r == BASE_W'(SEQ_DEPTH - 1))
             || (cnt_r == CNT_W'(MAX_DELIVER - 1));

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    flags_nxt     = flags_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty && out_free) begin
          q_pop = 1'b1;
          if (dup || in_win) begin
            out_valid_nxt = 1'b1;
            out_nxt = '{kind: KIND_ACK, out_seq: q_data.seq, ack_checksum: ack_cks,
                        out_payload_hi: '0, out_payload_mid: '0, out_payload_lo: '0,
                        last: 1'b1};
          end
          if (!dup && in_win) begin
            ram_we         = 1'b1;
            flags_nxt[off] = 1'b1;
            // a packet at base starts a drain run
            if (off == '0) begin
              out_nxt.last = 1'b0;
              cnt_nxt      = '0;
              state_nxt    = BK_READ;
            end
          end
        end
      end
      BK_READ: begin
        ram_re    = 1'b1;
        state_nxt = BK_DELIVER;
      end
      BK_DELIVER: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{kind: KIND_DELIVER, out_seq: base_r[SEQ_W-1:0], ack_checksum: '0,
                      out_payload_hi: ram_rdata[PAYLOAD_W-1 -: 64],
                      out_payload_mid: ram_rdata[95:32],
                      out_payload_lo: ram_rdata[31:0],
                      last: stop};
          base_nxt  = base_r + 1'b1;
          flags_nxt = flags_r >> 1;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = stop ? BK_IDLE : BK_READ;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      base_r      <= BASE_RESET;
      flags_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      flags_r     <= flags_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SRR_ASSERT_NOW(a_idle_base_unflagged, state_r == BK_IDLE, !flags_r[0], "base flagged at rest")
  `SRR_ASSERT_NOW(a_base_bound, 1'b1, base_r <= BASE_W'(SEQ_DEPTH), "base past store end")
  `SRR_ASSERT_NOW(a_deliver_flagged, state_r == BK_DELIVER, flags_r[0], "delivery unflagged")
  `SRR_ASSERT_NEXT(a_store_at_base_drains, q_pop && !dup && in_win && off == '0, state_r == BK_READ, "missed drain")

endmodule

// ===== hdl/selective_repeat_receiver_core.sv =====
// Top level of the selective-repeat receiver: config register and block wiring
//
//  Channel  | Direction | Handshake           | Payload
//  in_      | input     | in_valid/in_stall   | in_item_t (packet)
//  out_     | output    | out_valid/out_stall | out_item_t (ack or delivery)
//  cfg      | input     | APB psel/penable    | window_size at byte address 0
//
// Front end: the front register lies between acceptance and the queue (byte sums
// taken at acceptance, checksum compare in the next cycle); acks load from the queue head.
// Back end: BK_IDLE handles each duplicate, dropped or stored packet, then BK_READ and
// BK_DELIVER do each payload's store read and output load through the single read port.
// Reset: base 1, no flags set, window 8; no clearing pass is needed.
// A stall on out_ holds the output register; the queue and the front register then
// take up to three good items before in_stall rises.
module selective_repeat_receiver_core
  import srr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  in_item_t          in_data,
  output logic              in_stall,
  output logic              out_valid,
  output out_item_t         out_data,
  input  logic              out_stall,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [WIN_W-1:0] window_r, window_nxt;
  logic             q_push, q_pop;
  q_item_t          q_wdata, q_rdata;
  q_stat_t          q_stat;

  assign pready = 1'b1;

  always_comb begin
    window_nxt = window_r;
    if (psel && penable && pwrite && paddr[2] == REG_WINDOW_SIZE) begin
      window_nxt = pwdata[WIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else begin
      window_r <= window_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? CFG_DW'(window_r) : '0;

  srr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_stat   (q_stat)
  );

  srr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .q_stat (q_stat)
  );

  srr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .window_size (window_r),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .out_stall   (out_stall)
  );

endmodule
